FILE: hw/rtl/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared widths, constants and types of the signal strength meter.
// ----------------------------------------------------------------------------
package ssm_pkg;

    // sample format and averaging window
    localparam int SAMPLE_BITS = 16;
    localparam int WINDOW      = 30;
    localparam int IN_W        = 16;
    localparam int WIDE_W      = (SAMPLE_BITS > IN_W) ? SAMPLE_BITS : IN_W;
    localparam int POS_W       = $clog2(WINDOW);
    localparam int SUM_W       = SAMPLE_BITS + POS_W;

    // floor(sum / WINDOW) as a multiply by a rounded-up reciprocal
    localparam int RECIP_SHIFT = SUM_W + POS_W;
    localparam int RECIP_W     = SUM_W + 1;
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + longint'(WINDOW) - 64'd1) / longint'(WINDOW);
    localparam int PROD_W      = SUM_W + RECIP_W;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // log2 by repeated squaring, mantissa in Q30
    localparam int LOG_ROUNDS  = 16;
    localparam int MANT_FRAC   = 30;
    localparam int MANT_W      = MANT_FRAC + 1;
    localparam int SQ_W        = 2 * MANT_W;
    localparam int SHIFT_W     = $clog2(MANT_W);
    localparam int MSB_W       = $clog2(SAMPLE_BITS);

    // log2 to dB conversion
    localparam int E_W         = MSB_W + LOG_ROUNDS + 2;
    localparam int DBO_W       = 20;
    localparam logic signed [DBO_W-1:0] DB_PER_OCTAVE_Q16 = 20'sd394566;
    localparam int P_W         = E_W + DBO_W;
    localparam int Q32_TO_Q8   = 24;
    localparam int ROUND_Q32   = 1 << (Q32_TO_Q8 - 1);
    localparam int DB_W        = P_W - Q32_TO_Q8 + 1;
    localparam int DBQ_W       = 15;

    localparam int DBUV_MIN_Q8    = -9728;
    localparam int DBUV_MAX_Q8    = 15360;
    localparam int DBUV_OFFSET_Q8 = 15360;
    localparam int S9_DBUV_Q8     = 14592;
    localparam int S1_DBUV_Q8     = 768;
    localparam int HALF_DB_Q8     = 128;

    // s-unit step is 6 dB = 3 << 9 in Q8; divide by 3 as * 11 >> 5 for steps below 32
    localparam int S_STEP_SHIFT   = 9;
    localparam int S_STEP_W       = 5;
    localparam int S_DIV3_MUL     = 11;
    localparam int S_DIV3_SHIFT   = 5;
    localparam int S_PROD_W       = S_STEP_W + 4;
    localparam int S_UNIT_MAX     = 9;
    localparam int DB_FRAC_BITS   = 8;

    localparam int S_UNITS_W      = 4;
    localparam int OVER_W         = 2;

    // pipeline depth of the back part, output register included
    localparam int NUM_STAGES     = LOG_ROUNDS + 6;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [SUM_W-1:0]       sum;
    } item_t;

endpackage

FILE: hw/rtl/ssm_front.sv
// ----------------------------------------------------------------------------
// ssm_front
// Takes samples, keeps the sample window and its running sum, and queues
// the sample with the updated sum for the back part.
// ----------------------------------------------------------------------------
module ssm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [15:0]         peak_sample,
    input  logic                q_full,
    output logic                q_push,
    output ssm_pkg::item_t      q_item
);

    logic [ssm_pkg::SAMPLE_BITS-1:0] ring_reg [ssm_pkg::WINDOW];
    logic [ssm_pkg::POS_W-1:0]       pos_reg;
    logic [ssm_pkg::POS_W-1:0]       pos_next;
    logic [ssm_pkg::SUM_W-1:0]       sum_reg;
    logic [ssm_pkg::SUM_W-1:0]       sum_next;
    logic [ssm_pkg::WIDE_W-1:0]      wide_sample;
    logic [ssm_pkg::SAMPLE_BITS-1:0] sample;
    logic                            accept;

    // bits above the sample width are dropped
    assign wide_sample = ssm_pkg::WIDE_W'(peak_sample);
    assign sample      = wide_sample[ssm_pkg::SAMPLE_BITS-1:0];

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    assign sum_next = sum_reg - ssm_pkg::SUM_W'(ring_reg[pos_reg])
                      + ssm_pkg::SUM_W'(sample);
    assign pos_next = (pos_reg == ssm_pkg::POS_W'(ssm_pkg::WINDOW - 1))
                      ? '0 : pos_reg + 1'b1;

    assign q_push        = accept;
    assign q_item.sample = sample;
    assign q_item.sum    = sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ssm_pkg::WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
            pos_reg <= '0;
            sum_reg <= '0;
        end
        else if (accept)
        begin
            ring_reg[pos_reg] <= sample;
            pos_reg           <= pos_next;
            sum_reg           <= sum_next;
        end
    end

endmodule

FILE: hw/rtl/ssm_queue.sv
// ----------------------------------------------------------------------------
// ssm_queue
// Small first-in first-out queue of requests between front and back.
// ----------------------------------------------------------------------------
module ssm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ssm_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output ssm_pkg::item_t pop_item,
    output logic           empty
);

    ssm_pkg::item_t              q_reg [ssm_pkg::QUEUE_DEPTH];
    logic [ssm_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [ssm_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [ssm_pkg::QPTR_W:0]    count_reg;
    logic [ssm_pkg::QPTR_W:0]    count_next;
    logic                        do_push;
    logic                        do_pop;

    assign full     = (count_reg == (ssm_pkg::QPTR_W + 1)'(ssm_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = q_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hw/rtl/ssm_back.sv
// ----------------------------------------------------------------------------
// ssm_back
// Pipeline that forms the window average, picks the meter level, takes its
// log2 by repeated squaring and turns it into dBuV, S-units and dB over S9.
// ----------------------------------------------------------------------------
module ssm_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 average_mode,
    input  logic                                 q_empty,
    input  ssm_pkg::item_t                       q_item,
    output logic                                 q_pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [ssm_pkg::S_UNITS_W-1:0]        s_units,
    output logic [ssm_pkg::OVER_W-1:0]           over_s9_db,
    output logic signed [ssm_pkg::DBQ_W-1:0]     level_dbuv,
    output logic [15:0]                          average_level
);

    logic [ssm_pkg::NUM_STAGES-1:0] vld_reg;
    logic                           advance;

    // average and level selection
    logic [ssm_pkg::PROD_W-1:0]      prod_reg;
    logic [ssm_pkg::SAMPLE_BITS-1:0] samp0_reg;
    logic [ssm_pkg::SAMPLE_BITS-1:0] avg_c;
    logic [ssm_pkg::SAMPLE_BITS-1:0] avg1_reg;
    logic [ssm_pkg::SAMPLE_BITS-1:0] level1_reg;

    // normalization
    logic [ssm_pkg::MSB_W-1:0]       msb_c;
    logic [ssm_pkg::MANT_W-1:0]      mant_c;

    // squaring rounds, index 0 is the normalized value
    logic [ssm_pkg::MANT_W-1:0]       m_pipe_reg    [ssm_pkg::LOG_ROUNDS+1];
    logic [ssm_pkg::LOG_ROUNDS-1:0]   frac_pipe_reg [ssm_pkg::LOG_ROUNDS+1];
    logic [ssm_pkg::MSB_W-1:0]        msb_pipe_reg  [ssm_pkg::LOG_ROUNDS+1];
    logic                             zero_pipe_reg [ssm_pkg::LOG_ROUNDS+1];
    logic [ssm_pkg::SAMPLE_BITS-1:0]  avg_pipe_reg  [ssm_pkg::LOG_ROUNDS+1];
    logic [ssm_pkg::MANT_W-1:0]       m_next        [ssm_pkg::LOG_ROUNDS];
    logic                             bit_next      [ssm_pkg::LOG_ROUNDS];

    // dB conversion
    logic signed [ssm_pkg::E_W-1:0]   e_c;
    logic signed [ssm_pkg::P_W-1:0]   p_reg;
    logic                             zero_p_reg;
    logic [ssm_pkg::SAMPLE_BITS-1:0]  avg_p_reg;
    logic signed [ssm_pkg::P_W-1:0]   rnd_c;
    logic signed [ssm_pkg::DB_W-1:0]  q8_c;
    logic signed [ssm_pkg::DBQ_W-1:0] db_c;
    logic signed [ssm_pkg::DBQ_W-1:0] db_reg;
    logic [ssm_pkg::SAMPLE_BITS-1:0]  avg_db_reg;

    // output stage
    logic [ssm_pkg::DBQ_W-1:0]        s_diff_c;
    logic [ssm_pkg::S_STEP_W-1:0]     s_step_c;
    logic [ssm_pkg::S_PROD_W-1:0]     s_prod_c;
    logic [ssm_pkg::S_UNITS_W-1:0]    s_raw_c;
    logic [ssm_pkg::S_UNITS_W-1:0]    s_c;
    logic [ssm_pkg::DBQ_W-1:0]        over_diff_c;
    logic [ssm_pkg::OVER_W-1:0]       over_c;
    logic [ssm_pkg::WIDE_W-1:0]       avg_wide_c;

    logic [ssm_pkg::S_UNITS_W-1:0]    s_units_reg;
    logic [ssm_pkg::OVER_W-1:0]       over_s9_db_reg;
    logic signed [ssm_pkg::DBQ_W-1:0] level_dbuv_reg;
    logic [15:0]                      average_level_reg;

    // the whole pipe holds while a finished result waits
    assign advance   = !(vld_reg[ssm_pkg::NUM_STAGES-1] && out_stall);
    assign q_pop     = advance && !q_empty;
    assign out_valid = vld_reg[ssm_pkg::NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[ssm_pkg::NUM_STAGES-2:0], !q_empty};
        end
    end

    assign avg_c = prod_reg[ssm_pkg::RECIP_SHIFT +: ssm_pkg::SAMPLE_BITS];

    always_comb
    begin
        msb_c = '0;
        for (int i = 0; i < ssm_pkg::SAMPLE_BITS; i++)
        begin
            if (level1_reg[i])
            begin
                msb_c = ssm_pkg::MSB_W'(i);
            end
        end
        mant_c = ssm_pkg::MANT_W'(level1_reg)
                 << (ssm_pkg::SHIFT_W'(ssm_pkg::MANT_FRAC) - ssm_pkg::SHIFT_W'(msb_c));
    end

    always_comb
    begin
        logic [ssm_pkg::SQ_W-1:0]  sq;
        logic [ssm_pkg::MANT_W:0]  top;
        for (int g = 0; g < ssm_pkg::LOG_ROUNDS; g++)
        begin
            sq  = ssm_pkg::SQ_W'(m_pipe_reg[g]) * ssm_pkg::SQ_W'(m_pipe_reg[g]);
            top = sq[ssm_pkg::MANT_FRAC +: ssm_pkg::MANT_W + 1];
            // square reached [2,4): halve it and emit a one
            bit_next[g] = top[ssm_pkg::MANT_W];
            m_next[g]   = top[ssm_pkg::MANT_W] ? top[ssm_pkg::MANT_W:1]
                                               : top[ssm_pkg::MANT_W-1:0];
        end
    end

    assign e_c = $signed({2'b00, msb_pipe_reg[ssm_pkg::LOG_ROUNDS],
                          frac_pipe_reg[ssm_pkg::LOG_ROUNDS]})
                 - $signed(ssm_pkg::E_W'(ssm_pkg::SAMPLE_BITS) << ssm_pkg::LOG_ROUNDS);

    assign rnd_c = p_reg + ssm_pkg::P_W'(ssm_pkg::ROUND_Q32);
    assign q8_c  = ssm_pkg::DB_W'(rnd_c >>> ssm_pkg::Q32_TO_Q8)
                   + ssm_pkg::DB_W'(ssm_pkg::DBUV_OFFSET_Q8);

    always_comb
    begin
        if (zero_p_reg || q8_c < ssm_pkg::DBUV_MIN_Q8)
        begin
            db_c = ssm_pkg::DBQ_W'(ssm_pkg::DBUV_MIN_Q8);
        end
        else if (q8_c > ssm_pkg::DBUV_MAX_Q8)
        begin
            db_c = ssm_pkg::DBQ_W'(ssm_pkg::DBUV_MAX_Q8);
        end
        else
        begin
            db_c = ssm_pkg::DBQ_W'(q8_c);
        end
    end

    always_comb
    begin
        s_diff_c = db_reg - ssm_pkg::DBQ_W'(ssm_pkg::S1_DBUV_Q8);
        s_step_c = s_diff_c[ssm_pkg::S_STEP_SHIFT +: ssm_pkg::S_STEP_W];
        s_prod_c = ssm_pkg::S_PROD_W'(s_step_c) * ssm_pkg::S_PROD_W'(ssm_pkg::S_DIV3_MUL);
        s_raw_c  = s_prod_c[ssm_pkg::S_DIV3_SHIFT +: ssm_pkg::S_UNITS_W];
        if (db_reg < ssm_pkg::S1_DBUV_Q8)
        begin
            s_c = '0;
        end
        else if (s_raw_c > ssm_pkg::S_UNITS_W'(ssm_pkg::S_UNIT_MAX))
        begin
            s_c = ssm_pkg::S_UNITS_W'(ssm_pkg::S_UNIT_MAX);
        end
        else
        begin
            s_c = s_raw_c;
        end

        // level never exceeds S9 + 3 dB, so the rounded excess fits two bits
        over_diff_c = db_reg - ssm_pkg::DBQ_W'(ssm_pkg::S9_DBUV_Q8)
                      + ssm_pkg::DBQ_W'(ssm_pkg::HALF_DB_Q8);
        if (db_reg > ssm_pkg::S9_DBUV_Q8)
        begin
            over_c = over_diff_c[ssm_pkg::DB_FRAC_BITS +: ssm_pkg::OVER_W];
        end
        else
        begin
            over_c = '0;
        end
    end

    assign avg_wide_c = ssm_pkg::WIDE_W'(avg_db_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg  <= ssm_pkg::PROD_W'(q_item.sum) * ssm_pkg::PROD_W'(ssm_pkg::RECIP);
            samp0_reg <= q_item.sample;

            avg1_reg   <= avg_c;
            level1_reg <= average_mode ? avg_c : samp0_reg;

            m_pipe_reg[0]    <= mant_c;
            frac_pipe_reg[0] <= '0;
            msb_pipe_reg[0]  <= msb_c;
            zero_pipe_reg[0] <= (level1_reg == '0);
            avg_pipe_reg[0]  <= avg1_reg;

            for (int g = 0; g < ssm_pkg::LOG_ROUNDS; g++)
            begin
                m_pipe_reg[g+1]    <= m_next[g];
                frac_pipe_reg[g+1] <= {frac_pipe_reg[g][ssm_pkg::LOG_ROUNDS-2:0],
                                       bit_next[g]};
                msb_pipe_reg[g+1]  <= msb_pipe_reg[g];
                zero_pipe_reg[g+1] <= zero_pipe_reg[g];
                avg_pipe_reg[g+1]  <= avg_pipe_reg[g];
            end

            p_reg      <= ssm_pkg::P_W'(e_c) * ssm_pkg::P_W'(ssm_pkg::DB_PER_OCTAVE_Q16);
            zero_p_reg <= zero_pipe_reg[ssm_pkg::LOG_ROUNDS];
            avg_p_reg  <= avg_pipe_reg[ssm_pkg::LOG_ROUNDS];

            db_reg     <= db_c;
            avg_db_reg <= avg_p_reg;

            s_units_reg       <= s_c;
            over_s9_db_reg    <= over_c;
            level_dbuv_reg    <= db_reg;
            average_level_reg <= avg_wide_c[15:0];
        end
    end

    assign s_units       = s_units_reg;
    assign over_s9_db    = over_s9_db_reg;
    assign level_dbuv    = level_dbuv_reg;
    assign average_level = average_level_reg;

endmodule

FILE: hw/rtl/signal_strength_meter_unit.sv
// ----------------------------------------------------------------------------
// signal_strength_meter_unit
// Moving-average signal strength meter with dBuV and S-unit readout.
// ----------------------------------------------------------------------------
// One result per sample, one sample per clock sustained while out_stall is
// low. The front updates the window and sum and writes the four-entry
// request queue at the accepting edge; the back pops the request from the
// queue into the first of its 22 pipeline stages, 16 of them one squaring
// multiplier each for the log2, the last the output register.
// While out_stall holds a result, the back pipeline freezes and the queue
// keeps taking samples until it is full, when in_stall rises. average_mode
// selects the window average (1) or the raw peak (0) as the meter level; it
// is written through the cfg channel, always ready, and takes effect for
// samples that reach the level select after the write.
module signal_strength_meter_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [15:0]                          peak_sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [3:0]                           s_units,
    output logic [1:0]                           over_s9_db,
    output logic signed [14:0]                   level_dbuv,
    output logic [15:0]                          average_level,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_data
);

    logic           average_mode_reg;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    ssm_pkg::item_t push_item;
    ssm_pkg::item_t pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            average_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            average_mode_reg <= cfg_data;
        end
    end

    ssm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .peak_sample (peak_sample),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    ssm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    ssm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .average_mode  (average_mode_reg),
        .q_empty       (q_empty),
        .q_item        (pop_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .s_units       (s_units),
        .over_s9_db    (over_s9_db),
        .level_dbuv    (level_dbuv),
        .average_level (average_level)
    );

endmodule
